// ===== rtl/iba_pkg.sv =====
// Package for the identifier bitmap allocator: field widths, status codes
// and the result payload type. No dependencies.
`default_nettype none

package iba_pkg;

   localparam int ID_FIELD_W = 6;
   localparam int STATUS_W   = 2;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_ALLOCATED = 2'd0;
   localparam status_type ST_FULL      = 2'd1;
   localparam status_type ST_RELEASED  = 2'd2;
   localparam status_type ST_IGNORED   = 2'd3;

   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_RELEASE  = 1'b1;

   typedef logic [ID_FIELD_W-1:0] id_field_type;

endpackage

`default_nettype wire

// ===== rtl/iba_req_if.sv =====
// Request and response channel interfaces of the identifier bitmap allocator.
// Depends on iba_pkg for field types.
`default_nettype none

interface iba_req_if import iba_pkg::*; ();
   logic         valid;
   logic         ready;
   logic         op;
   id_field_type release_id;

   modport source (output valid, output op, output release_id, input ready);
   modport sink   (input valid, input op, input release_id, output ready);
endinterface

interface iba_rsp_if import iba_pkg::*; ();
   logic         valid;
   logic         ready;
   id_field_type granted_id;
   status_type   status;
   id_field_type highest_id;

   modport source (output valid, output granted_id, output status, output highest_id,
                   input ready);
   modport sink   (input valid, input granted_id, input status, input highest_id,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/id_bitmap_allocator.sv =====
// Identifier bitmap allocator: first-fit allocate and checked release over a
// fixed bitmap of NUM_IDS identifiers. Depends on iba_pkg and the channel
// interfaces in iba_req_if.sv.
//
// Usage: requests arrive on req_bus. An allocate transaction (op = 0) claims
// the lowest free identifier, identifier 0 included; a release transaction
// (op = 1) frees release_id if it is nonzero, inside the map and allocated.
// Every request produces exactly one response transaction on rsp_bus that
// carries the granted identifier, a status code and the highest identifier
// still allocated after the request.
// The response is registered and shows on rsp_bus the cycle after the request
// is accepted. Throughput is one request per cycle while the receiver keeps
// ready high; the lowest-free and highest-used searches are combinational
// priority encoders over the bitmap register.
// When the map is full an allocate changes nothing and reports full status.
// Reset (synchronous, active high) clears the whole bitmap at once and drops
// the response valid, so the block accepts requests in the first cycle after
// reset. If the receiver stalls, the held response stays stable and a new
// request is accepted only in the cycle the held one is taken.
`default_nettype none

module id_bitmap_allocator
   import iba_pkg::*;
#(
   parameter int NUM_IDS = 64
) (
   input  wire          clock,
   input  wire          reset,
   iba_req_if.sink      req_bus,
   iba_rsp_if.source    rsp_bus
);

   // Internal index width: wide enough for any identifier, never narrower
   // than the result fields so that truncation to them is a plain select.
   localparam int MAP_IW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
   localparam int IW     = (MAP_IW > ID_FIELD_W) ? MAP_IW : ID_FIELD_W;

   logic [NUM_IDS-1:0] map_ff, map_in;
   logic               rsp_valid_ff, rsp_valid_in;
   id_field_type       granted_ff, granted_in;
   status_type         status_ff, status_in;
   id_field_type       highest_ff, highest_in;

   logic               accept;
   logic [NUM_IDS-1:0] free_bits;
   logic [NUM_IDS-1:0] free_onehot;
   logic               free_found;
   logic [IW-1:0]      free_idx;
   logic [IW-1:0]      rid_ext;
   logic [NUM_IDS-1:0] rel_onehot;
   logic               rel_hit;
   logic [NUM_IDS-1:0] kept_map;
   logic               old_any;
   logic [IW-1:0]      old_top;
   logic [IW-1:0]      kept_top;
   logic [IW-1:0]      alloc_top;

   // A new request enters whenever the output register is empty or is being
   // emptied in this same cycle.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   // Lowest free identifier: isolate the lowest set bit of the free mask.
   assign free_bits   = ~map_ff;
   assign free_onehot = free_bits & (~free_bits + NUM_IDS'(1));
   assign free_found  = |free_bits;

   always_comb begin
      free_idx = '0;
      for (int k = 0; k < NUM_IDS; k++) begin
         if (free_onehot[k]) begin
            free_idx = IW'(k);
         end
      end
   end

   // Release decode. Identifier 0 and identifiers past the map never match,
   // so such releases fall through as ignored.
   assign rid_ext = IW'(req_bus.release_id);

   always_comb begin
      for (int k = 0; k < NUM_IDS; k++) begin
         rel_onehot[k] = (k != 0) && (IW'(k) == rid_ext);
      end
   end

   assign rel_hit  = |(rel_onehot & map_ff);
   assign kept_map = map_ff & ~rel_onehot;

   // Highest used identifier, before the request and with the release
   // applied; both searches run in parallel with the free search.
   always_comb begin
      old_any  = 1'b0;
      old_top  = '0;
      kept_top = '0;
      for (int k = 0; k < NUM_IDS; k++) begin
         if (map_ff[k]) begin
            old_any = 1'b1;
            old_top = IW'(k);
         end
         if (kept_map[k]) begin
            kept_top = IW'(k);
         end
      end
   end

   // After an allocate the highest identifier is the larger of the old top
   // and the identifier just granted.
   assign alloc_top = (old_any && (old_top > free_idx)) ? old_top : free_idx;

   always_comb begin
      map_in       = map_ff;
      rsp_valid_in = rsp_valid_ff;
      granted_in   = granted_ff;
      status_in    = status_ff;
      highest_in   = highest_ff;

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         rsp_valid_in = 1'b1;
         if (req_bus.op == OP_ALLOCATE) begin
            if (free_found) begin
               map_in     = map_ff | free_onehot;
               granted_in = free_idx[ID_FIELD_W-1:0];
               status_in  = ST_ALLOCATED;
               highest_in = alloc_top[ID_FIELD_W-1:0];
            end else begin
               granted_in = '0;
               status_in  = ST_FULL;
               highest_in = old_top[ID_FIELD_W-1:0];
            end
         end else begin
            map_in     = kept_map;
            granted_in = '0;
            status_in  = rel_hit ? ST_RELEASED : ST_IGNORED;
            highest_in = kept_top[ID_FIELD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         map_ff       <= map_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload holds its value while stalled; it needs no reset.
   always_ff @(posedge clock) begin
      granted_ff <= granted_in;
      status_ff  <= status_in;
      highest_ff <= highest_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.granted_id = granted_ff;
   assign rsp_bus.status     = status_ff;
   assign rsp_bus.highest_id = highest_ff;

endmodule

`default_nettype wire

// ===== bench/id_bitmap_allocator_tb.sv =====
// Self-checking bench for the identifier bitmap allocator: directed and random
// request traffic with random idling on both channels, checked by a scoreboard.
// Depends on iba_pkg, iba_req_if.sv and id_bitmap_allocator.sv.
`default_nettype none

module id_bitmap_allocator_tb;
   import iba_pkg::*;

   localparam int NUM_IDS     = 64;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_WAIT  = 6;

   // One expected response transaction, in the order the block returns them.
   typedef struct packed {
      id_field_type granted_id;
      status_type   status;
      id_field_type highest_id;
   } grant_result_type;

   // The scoreboard keeps its own copy of the allocation bitmap. Every accepted
   // request transaction advances that copy and queues the response it should
   // cause; every accepted response transaction is checked against the oldest
   // entry of that queue.
   class id_allocator_scoreboard;
      bit [NUM_IDS-1:0] used_map;
      grant_result_type pending_grants[$];
      int unsigned      errors;
      int unsigned      grant_count;
      int unsigned      full_count;
      int unsigned      release_count;
      int unsigned      ignored_count;

      function new();
         used_map      = '0;
         errors        = 0;
         grant_count   = 0;
         full_count    = 0;
         release_count = 0;
         ignored_count = 0;
      endfunction

      function void note_request(logic op, id_field_type rid);
         grant_result_type result;
         int               top;
         result.granted_id = '0;
         if (op == OP_ALLOCATE) begin
            result.status = ST_FULL;
            for (int k = 0; k < NUM_IDS; k++) begin
               if (!used_map[k]) begin
                  used_map[k]       = 1'b1;
                  result.granted_id = id_field_type'(k);
                  result.status     = ST_ALLOCATED;
                  break;
               end
            end
         end else begin
            // Identifier 0 is never freed, nor is anything outside the map.
            result.status = ST_IGNORED;
            if (rid != 0 && int'(rid) < NUM_IDS && used_map[rid]) begin
               used_map[rid] = 1'b0;
               result.status = ST_RELEASED;
            end
         end
         top = 0;
         for (int k = 0; k < NUM_IDS; k++)
            if (used_map[k])
               top = k;
         result.highest_id = id_field_type'(top);
         case (result.status)
            ST_ALLOCATED: grant_count++;
            ST_FULL:      full_count++;
            ST_RELEASED:  release_count++;
            default:      ignored_count++;
         endcase
         pending_grants.push_back(result);
      endfunction

      function void check_response(id_field_type granted, status_type status,
                                   id_field_type highest);
         grant_result_type want;
         if (pending_grants.size() == 0) begin
            $error("response transaction with no request outstanding");
            errors++;
            return;
         end
         want = pending_grants.pop_front();
         if (granted !== want.granted_id) begin
            $error("granted_id: expected %0d, got %0d", want.granted_id, granted);
            errors++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
         end
         if (highest !== want.highest_id) begin
            $error("highest_id: expected %0d, got %0d", want.highest_id, highest);
            errors++;
         end
      endfunction

      function int pending();
         return pending_grants.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   iba_req_if req_bus ();
   iba_rsp_if rsp_bus ();

   id_bitmap_allocator #(
      .NUM_IDS (NUM_IDS)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   id_allocator_scoreboard sb = new();

   // Idling is switched per phase; while it is off both channels run flat out.
   bit          allow_idle;
   int unsigned cycle_count;
   int unsigned requests_sent;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Generous watchdog: the slowest legal run is far below this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("id_bitmap_allocator_tb NOT OK");
         $finish;
      end
   end

   // Both monitors sample at the rising edge, before the block's registers move.
   // A request accepted at one edge can only answer at a later edge, so the
   // note always precedes the matching check.
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         sb.note_request(req_bus.op, req_bus.release_id);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_response(rsp_bus.granted_id, rsp_bus.status, rsp_bus.highest_id);
   end

   // The receiver alternates ready stretches with stall bursts.
   // Ready changes only at the falling edge, and never twice in one step.
   initial begin
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (allow_idle && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
         rsp_bus.ready = 1'b1;
         repeat ($urandom_range(1, 30)) @(negedge clock);
      end
   end

   // Drives one request transaction, starting and ending at a falling edge.
   // Valid stays high between back-to-back transactions; it drops only for an
   // idle burst or at the very end.
   task automatic send_request(input logic op, input id_field_type rid);
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.op         = op;
      req_bus.release_id = rid;
      do
         @(posedge clock);
      while (!req_bus.ready);
      requests_sent++;
      @(negedge clock);
   endtask

   // A phase of random traffic with a given allocate share in percent. Most
   // releases name an identifier that is held right now, so the map really
   // empties again; the rest name any identifier and are mostly ignored.
   task automatic run_mixed_phase(input int alloc_pct, input int count);
      logic         op;
      id_field_type rid;
      int           start;
      int           k;
      for (int n = 0; n < count; n++) begin
         op  = ($urandom_range(1, 100) <= alloc_pct) ? OP_ALLOCATE : OP_RELEASE;
         rid = id_field_type'($urandom_range(0, NUM_IDS - 1));
         if (op == OP_RELEASE && sb.used_map != '0 && $urandom_range(0, 9) < 7) begin
            start = $urandom_range(0, NUM_IDS - 1);
            for (k = 0; k < NUM_IDS; k++) begin
               if (sb.used_map[(start + k) % NUM_IDS]) begin
                  rid = id_field_type'((start + k) % NUM_IDS);
                  break;
               end
            end
         end
         send_request(op, rid);
      end
   endtask

   initial begin
      int alloc_pct;
      req_bus.valid      = 1'b0;
      req_bus.op         = OP_ALLOCATE;
      req_bus.release_id = '0;
      reset              = 1'b1;
      allow_idle         = 1'b0;
      requests_sent      = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. Identifier 0 is handed out first and can never be freed;
      // a release of a free identifier is ignored; a freed hole is refilled
      // before anything higher; the highest identifier falls back as the top
      // entries are freed. The release field is ignored on an allocate.
      send_request(OP_ALLOCATE, 6'd0);
      send_request(OP_RELEASE,  6'd0);
      send_request(OP_RELEASE,  6'd63);
      send_request(OP_ALLOCATE, 6'd63);
      send_request(OP_ALLOCATE, 6'd42);
      send_request(OP_ALLOCATE, 6'd21);
      send_request(OP_RELEASE,  6'd2);
      send_request(OP_RELEASE,  6'd2);
      send_request(OP_ALLOCATE, 6'd0);
      send_request(OP_RELEASE,  6'd3);
      send_request(OP_RELEASE,  6'd1);
      send_request(OP_RELEASE,  6'd2);
      send_request(OP_RELEASE,  6'd42);
      send_request(OP_RELEASE,  6'd21);
      send_request(OP_RELEASE,  6'd0);

      // Fill the map completely, then keep asking so the full status shows up;
      // free the top identifier and take it back.
      allow_idle = 1'b1;
      run_mixed_phase(100, NUM_IDS + 2);
      send_request(OP_RELEASE,  6'd63);
      send_request(OP_ALLOCATE, 6'd0);
      send_request(OP_ALLOCATE, 6'd0);

      // Random phases of varying pressure: some drive the map to full, some
      // drain it to empty, some hover in between. Some phases run with no idling.
      while (requests_sent < 750) begin
         case ($urandom_range(0, 4))
            0:       alloc_pct = 95;
            1:       alloc_pct = 65;
            2:       alloc_pct = 50;
            3:       alloc_pct = 25;
            default: alloc_pct = 5;
         endcase
         allow_idle = ($urandom_range(0, 3) != 0);
         run_mixed_phase(alloc_pct, $urandom_range(20, 120));
      end

      // Final stretch at full rate on both sides.
      allow_idle = 1'b0;
      run_mixed_phase(70, 80);
      run_mixed_phase(30, 80);
      req_bus.valid = 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d requests: %0d grants, %0d full refusals, %0d releases, %0d ignored",
               requests_sent, sb.grant_count, sb.full_count, sb.release_count,
               sb.ignored_count);
      $display("%0d mismatches in %0d cycles", sb.errors, cycle_count);
      if (sb.errors == 0)
         $display("id_bitmap_allocator_tb OK");
      else
         $display("id_bitmap_allocator_tb NOT OK");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/iba_pkg.sv
rtl/iba_req_if.sv
rtl/id_bitmap_allocator.sv
bench/id_bitmap_allocator_tb.sv
